// ===== sv/i2cm_pkg.sv =====
// Shared types and codes for the I2C bit-level master.
// No dependencies; the interfaces and all modules import this package.
package i2cm_pkg;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_WACK  = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd250;
    localparam logic [3:0] BITS_PER_BYTE        = 4'd8;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_level;
    } tick_item_t;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_failed;
    } result_item_t;

endpackage

// ===== sv/i2cm_if.sv =====
// Valid/ready channel interfaces for tick items and result items.
// Depends on i2cm_pkg.
interface i2cm_tick_if
    import i2cm_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_level;

    modport source (output valid, command, data_byte, send_ack, sda_level, input ready);
    modport sink   (input valid, command, data_byte, send_ack, sda_level, output ready);
endinterface

interface i2cm_result_if
    import i2cm_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;

    modport source (output valid, scl_drive, sda_drive, busy_res, done_res, read_data,
                    ack_failed, input ready);
    modport sink   (input valid, scl_drive, sda_drive, busy_res, done_res, read_data,
                    ack_failed, output ready);
endinterface

// ===== sv/i2cm_seq.sv =====
// Bus sequencer: phase state, counters and pin levels, one tick per step.
// Depends on i2cm_pkg.
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  tick_item_t   item,
    input  logic [7:0]   ack_poll_limit,
    output result_item_t res
);

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST1  = 5'd1;
    localparam logic [4:0] PH_ST2  = 5'd2;
    localparam logic [4:0] PH_ST3  = 5'd3;
    localparam logic [4:0] PH_ST4  = 5'd4;
    localparam logic [4:0] PH_ST5  = 5'd5;
    localparam logic [4:0] PH_ST6  = 5'd6;
    localparam logic [4:0] PH_SP1  = 5'd7;
    localparam logic [4:0] PH_SP2  = 5'd8;
    localparam logic [4:0] PH_SP3  = 5'd9;
    localparam logic [4:0] PH_WBA  = 5'd10;
    localparam logic [4:0] PH_WBB  = 5'd11;
    localparam logic [4:0] PH_WBC  = 5'd12;
    localparam logic [4:0] PH_WBE  = 5'd13;
    localparam logic [4:0] PH_WAR  = 5'd14;
    localparam logic [4:0] PH_WAC  = 5'd15;
    localparam logic [4:0] PH_WAP  = 5'd16;
    localparam logic [4:0] PH_WAL  = 5'd17;
    localparam logic [4:0] PH_WAE  = 5'd18;
    localparam logic [4:0] PH_RBH  = 5'd19;
    localparam logic [4:0] PH_RBL  = 5'd20;
    localparam logic [4:0] PH_AK1  = 5'd21;
    localparam logic [4:0] PH_AK2  = 5'd22;
    localparam logic [4:0] PH_AK3  = 5'd23;
    localparam logic [4:0] PH_AK4  = 5'd24;

    logic [4:0] phase_reg, phase_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] poll_cnt_reg, poll_cnt_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       ack_fail_reg, ack_fail_next;
    logic [7:0] read_hold_reg, read_hold_next;

    always_comb
    begin
        logic [4:0] ph;
        logic       busy;
        logic       done;
        ph              = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        poll_cnt_next   = poll_cnt_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_choice_next = ack_choice_reg;
        ack_fail_next   = ack_fail_reg;
        read_hold_next  = read_hold_reg;
        busy            = 1'b0;
        done            = 1'b0;
        phase_next      = PH_IDLE;

        // idle: a command starts its sequence on this same tick
        if (phase_reg == PH_IDLE)
        begin
            bit_cnt_next  = '0;
            poll_cnt_next = '0;
            case (item.command)
                CMD_START: ph = PH_ST1;
                CMD_STOP:  ph = PH_SP1;
                CMD_WRITE:
                begin
                    shift_next = item.data_byte;
                    ph         = PH_WBA;
                end
                CMD_WACK:
                begin
                    ack_fail_next = 1'b0;
                    ph            = PH_WAR;
                end
                CMD_READ:
                begin
                    shift_next      = '0;
                    ack_choice_next = item.send_ack;
                    ph              = PH_RBH;
                end
                default: ph = PH_IDLE;
            endcase
        end

        if (ph != PH_IDLE)
        begin
            busy = 1'b1;
            case (ph)
                PH_ST1: begin scl_next = 1'b0; phase_next = PH_ST2; end
                PH_ST2: begin sda_next = 1'b1; phase_next = PH_ST3; end
                PH_ST3: begin scl_next = 1'b1; phase_next = PH_ST4; end
                PH_ST4: begin sda_next = 1'b0; phase_next = PH_ST5; end
                PH_ST5: begin scl_next = 1'b0; phase_next = PH_ST6; end
                PH_ST6: begin sda_next = 1'b1; done = 1'b1; end
                PH_SP1:
                begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_SP2;
                end
                PH_SP2: begin scl_next = 1'b1; phase_next = PH_SP3; end
                PH_SP3: begin sda_next = 1'b1; done = 1'b1; end
                PH_WBA:
                begin
                    scl_next   = 1'b0;
                    sda_next   = shift_next[7];
                    shift_next = {shift_next[6:0], 1'b0};
                    phase_next = PH_WBB;
                end
                PH_WBB: begin scl_next = 1'b1; phase_next = PH_WBC; end
                PH_WBC:
                begin
                    scl_next     = 1'b0;
                    bit_cnt_next = bit_cnt_next + 4'd1;
                    phase_next   = (bit_cnt_next >= BITS_PER_BYTE) ? PH_WBE : PH_WBA;
                end
                PH_WBE: begin sda_next = 1'b1; done = 1'b1; end
                PH_WAR: begin sda_next = 1'b1; phase_next = PH_WAC; end
                PH_WAC: begin scl_next = 1'b1; phase_next = PH_WAP; end
                PH_WAP:
                begin
                    if (!item.sda_level)
                    begin
                        phase_next = PH_WAL;
                    end
                    else if (poll_cnt_next >= ack_poll_limit)
                    begin
                        // timeout: first stop action now, rest of stop follows
                        ack_fail_next = 1'b1;
                        scl_next      = 1'b0;
                        sda_next      = 1'b0;
                        phase_next    = PH_SP2;
                    end
                    else
                    begin
                        poll_cnt_next = poll_cnt_next + 8'd1;
                        phase_next    = PH_WAP;
                    end
                end
                PH_WAL: begin scl_next = 1'b0; phase_next = PH_WAE; end
                PH_WAE: begin sda_next = 1'b1; done = 1'b1; end
                PH_RBH:
                begin
                    scl_next   = 1'b1;
                    shift_next = {shift_next[6:0], item.sda_level};
                    phase_next = PH_RBL;
                end
                PH_RBL:
                begin
                    scl_next     = 1'b0;
                    bit_cnt_next = bit_cnt_next + 4'd1;
                    if (bit_cnt_next >= BITS_PER_BYTE)
                    begin
                        read_hold_next = shift_next;
                        phase_next     = PH_AK1;
                    end
                    else
                    begin
                        phase_next = PH_RBH;
                    end
                end
                PH_AK1: begin sda_next = ~ack_choice_next; phase_next = PH_AK2; end
                PH_AK2: begin scl_next = 1'b1; phase_next = PH_AK3; end
                PH_AK3:
                begin
                    scl_next = 1'b0;
                    if (ack_choice_next)
                        phase_next = PH_AK4;
                    else
                        done = 1'b1;
                end
                PH_AK4: begin sda_next = 1'b1; done = 1'b1; end
                default: phase_next = PH_IDLE;
            endcase
        end

        res.scl_drive  = scl_next;
        res.sda_drive  = sda_next;
        res.busy_res   = busy;
        res.done_res   = done;
        res.read_data  = read_hold_next;
        res.ack_failed = ack_fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= '0;
            shift_reg      <= '0;
            poll_cnt_reg   <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_choice_reg <= 1'b0;
            ack_fail_reg   <= 1'b0;
            read_hold_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            poll_cnt_reg   <= poll_cnt_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_choice_reg <= ack_choice_next;
            ack_fail_reg   <= ack_fail_next;
            read_hold_reg  <= read_hold_next;
        end
    end

endmodule

// ===== sv/i2c_bit_level_master.sv =====
// Top level of the I2C bit-level master: tick register, sequencer, result register.
// Depends on i2cm_pkg, i2cm_if (both channel interfaces) and i2cm_seq.
//
// Usage:
//  - tick (sink): one item per bus delay interval. It carries the sampled SDA
//    level and, while no sequence runs, a command (start, stop, write byte,
//    wait ack, read byte). Commands arriving during a sequence are dropped.
//  - result (source): exactly one item per tick item, in order: SCL/SDA drive
//    levels after the tick's action, busy/done flags, last read byte and the
//    ack-timeout flag.
//  - ack_limit_we/ack_limit_wdata: writes the ack poll limit (reset 250);
//    write only while no tick item is in flight.
// Path: an accepted tick item waits in the tick register; the sequencer's
// result for it is then captured in the result register.
// Throughput: one tick item per cycle unless the result side stalls; the sequencer
// steps once per cycle as the tick register hands its item to the result register.
// Reset: both registers empty, bus released (SCL and SDA high), no sequence.
// Stall: when the result receiver holds ready low, the result register keeps
// its item, the tick register fills, and tick.ready then drops until the
// result is taken. Nothing is lost or repeated.
module i2c_bit_level_master
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    i2cm_tick_if.sink  tick,
    i2cm_result_if.source result,
    input  logic       ack_limit_we,
    input  logic [7:0] ack_limit_wdata
);

    logic [7:0]   ack_limit_reg;
    logic         tick_valid_reg;
    tick_item_t   tick_item_reg;
    logic         res_valid_reg;
    result_item_t res_item_reg;
    result_item_t res_next;
    logic         advance;
    logic         tick_fire;

    // the sequencer steps when the held tick item moves into the result stage
    assign advance   = tick_valid_reg && (!res_valid_reg || result.ready);
    assign tick.ready = !tick_valid_reg || advance;
    assign tick_fire = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ack_limit_reg <= ACK_POLL_LIMIT_RESET;
        else if (ack_limit_we)
            ack_limit_reg <= ack_limit_wdata;
    end

    // tick register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (tick.ready)
            tick_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            tick_item_reg.command   <= tick.command;
            tick_item_reg.data_byte <= tick.data_byte;
            tick_item_reg.send_ack  <= tick.send_ack;
            tick_item_reg.sda_level <= tick.sda_level;
        end
    end

    i2cm_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .item           (tick_item_reg),
        .ack_poll_limit (ack_limit_reg),
        .res            (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (!res_valid_reg || result.ready)
            res_valid_reg <= tick_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_item_reg <= res_next;
    end

    assign result.valid      = res_valid_reg;
    assign result.scl_drive  = res_item_reg.scl_drive;
    assign result.sda_drive  = res_item_reg.sda_drive;
    assign result.busy_res   = res_item_reg.busy_res;
    assign result.done_res   = res_item_reg.done_res;
    assign result.read_data  = res_item_reg.read_data;
    assign result.ack_failed = res_item_reg.ack_failed;

    // a completing tick is always a busy tick
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.done_res |-> res_next.busy_res)
        else $error("done without busy");

    // the tick side only backs up when the result side is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> result.valid && !result.ready)
        else $error("tick channel stalled without result stall");

    // a held tick item that cannot move is still held next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid_reg && !advance |=> tick_valid_reg)
        else $error("tick item lost");

endmodule
